>>> src/sstw_pkg.sv
// ----------------------------------------------------------------------------
// sstw_pkg
// Shared types, protocol bytes and the segment decode table for the
// two-wire seven-segment writer.
// ----------------------------------------------------------------------------
package sstw_pkg;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_DIGITS  = 2'd1,
    KIND_CONTROL = 2'd2,
    KIND_ALLON   = 2'd3
  } kind_t;

  localparam logic [7:0] ADDR_CMD   = 8'b1100_0000;
  localparam logic [7:0] DATA_CMD   = 8'b0100_0000;
  localparam logic [7:0] CTRL_ON    = 8'b1000_1000;
  localparam logic [7:0] CTRL_OFF   = 8'b1000_0000;
  localparam logic [7:0] ALL_SEG    = 8'hFF;
  localparam logic [7:0] COLON_MASK = 8'h80;
  localparam logic [15:0] DELAY_RESET = 16'd360;

  // One classified tick as it travels from the front to the back.
  typedef struct packed {
    kind_t           kind;
    logic [3:0][7:0] seg;
    logic [7:0]      first_byte;
    logic            dio_in;
  } item_t;

  function automatic logic [7:0] seg_of(input logic [7:0] code);
    logic [7:0] s;
    unique case (code)
      8'd0:    s = 8'b0011_1111;
      8'd1:    s = 8'b0000_0110;
      8'd2:    s = 8'b0101_1011;
      8'd3:    s = 8'h4F;
      8'd4:    s = 8'h66;
      8'd5:    s = 8'h6D;
      8'd6:    s = 8'h7D;
      8'd7:    s = 8'h07;
      8'd8:    s = 8'h7F;
      8'd9:    s = 8'b0110_1111;
      8'd65:   s = 8'b0111_0111;
      8'd69:   s = 8'b0111_1001;
      8'd101:  s = 8'b0111_1011;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

>>> src/seven_segment_two_wire_writer.sv
// ----------------------------------------------------------------------------
// seven_segment_two_wire_writer
// Two-wire serial writer for a four-digit seven-segment LED driver.
//
//   channel   direction  word
//   in        input      kind, digit_first..digit_fourth, colon, display_on, dio_in
//   out       output     clk_level, dio_level, busy_res, done_res, status
//   cfg       input      cfg_data = delay_ticks
//
// One word in gives one word out; one word per cycle sustained while out_ready is high.
// Each word passes through the queue and then the output register.
// Reset (rst, synchronous): idle, internal line levels high (the level outputs are not reset), delay_ticks = 360.
// A stalled output fills the queue, then in_ready drops.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_writer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  digit_first,
  input  logic [7:0]  digit_second,
  input  logic [7:0]  digit_third,
  input  logic [7:0]  digit_fourth,
  input  logic        colon,
  input  logic        display_on,
  input  logic        dio_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clk_level,
  output logic        dio_level,
  output logic        busy_res,
  output logic        done_res,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  sstw_pkg::item_t front_item;
  sstw_pkg::item_t back_item;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;

  assign in_ready  = q_ready;
  assign cfg_ready = 1'b1;

  sstw_front u_front (
    .kind         (kind),
    .digit_first  (digit_first),
    .digit_second (digit_second),
    .digit_third  (digit_third),
    .digit_fourth (digit_fourth),
    .colon        (colon),
    .display_on   (display_on),
    .dio_in       (dio_in),
    .item         (front_item)
  );

  sstw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && q_ready),
    .push_item  (front_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_item   (back_item),
    .pop_valid  (q_valid)
  );

  sstw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item       (back_item),
    .item_valid (q_valid),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .clk_level  (clk_level),
    .dio_level  (dio_level),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .status     (status)
  );

endmodule

>>> src/sstw_front.sv
// ----------------------------------------------------------------------------
// sstw_front
// Accepts ticks, decodes digit codes to segment bytes and picks the first
// byte of the command.
// ----------------------------------------------------------------------------
module sstw_front (
  input  logic                [1:0] kind,
  input  logic                [7:0] digit_first,
  input  logic                [7:0] digit_second,
  input  logic                [7:0] digit_third,
  input  logic                [7:0] digit_fourth,
  input  logic                      colon,
  input  logic                      display_on,
  input  logic                      dio_in,
  output sstw_pkg::item_t           item
);

  always_comb begin
    item.kind   = sstw_pkg::kind_t'(kind);
    item.dio_in = dio_in;
    item.seg[0] = sstw_pkg::seg_of(digit_first);
    item.seg[1] = sstw_pkg::seg_of(digit_second) | (colon ? sstw_pkg::COLON_MASK : 8'h00);
    item.seg[2] = sstw_pkg::seg_of(digit_third);
    item.seg[3] = sstw_pkg::seg_of(digit_fourth);
    unique case (item.kind)
      sstw_pkg::KIND_DIGITS:  item.first_byte = sstw_pkg::ADDR_CMD;
      sstw_pkg::KIND_CONTROL: item.first_byte = display_on ? sstw_pkg::CTRL_ON
                                                           : sstw_pkg::CTRL_OFF;
      default:                item.first_byte = sstw_pkg::DATA_CMD;
    endcase
  end

endmodule

>>> src/sstw_queue.sv
// ----------------------------------------------------------------------------
// sstw_queue
// Small FIFO of classified ticks between front and back.
// ----------------------------------------------------------------------------
module sstw_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sstw_pkg::item_t push_item,
  output logic            push_ready,
  input  logic            pop,
  output sstw_pkg::item_t pop_item,
  output logic            pop_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sstw_pkg::item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/sstw_back.sv
// ----------------------------------------------------------------------------
// sstw_back
// Two-wire bus sequencer: steps once per word popped from the queue and
// registers the line levels and status for the output channel.
// ----------------------------------------------------------------------------
module sstw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [15:0]     cfg_data,
  input  sstw_pkg::item_t item,
  input  logic            item_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            clk_level,
  output logic            dio_level,
  output logic            busy_res,
  output logic            done_res,
  output logic            status
);

  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_START1   = 11'b000_0000_0010,
    PH_START2   = 11'b000_0000_0100,
    PH_BIT_LOW  = 11'b000_0000_1000,
    PH_BIT_HIGH = 11'b000_0001_0000,
    PH_ACK1     = 11'b000_0010_0000,
    PH_ACK2     = 11'b000_0100_0000,
    PH_ACK3     = 11'b000_1000_0000,
    PH_STOP1    = 11'b001_0000_0000,
    PH_STOP2    = 11'b010_0000_0000,
    PH_STOP3    = 11'b100_0000_0000
  } phase_t;

  logic [15:0]     delay_ticks;
  phase_t          phase, phase_next;
  logic [15:0]     delay_count, delay_count_next;
  logic [2:0]      bit_index, bit_index_next;
  logic [2:0]      byte_index, byte_index_next;
  logic [7:0]      shift_byte, shift_byte_next;
  logic [3:0][7:0] seg;
  sstw_pkg::kind_t cmd, cmd_next;
  logic            line_clk, line_clk_next;
  logic            line_dio, line_dio_next;

  logic            go_en;
  phase_t          go_ph;
  logic [15:0]     dur;
  logic            more;
  logic            start;
  logic            done_w;
  logic            status_w;
  logic            data_bit;

  assign pop   = item_valid && (!out_valid || out_ready);
  assign start = (phase == PH_IDLE) && (item.kind != sstw_pkg::KIND_TICK);

  always_comb begin
    phase_next       = phase;
    delay_count_next = delay_count;
    bit_index_next   = bit_index;
    byte_index_next  = byte_index;
    shift_byte_next  = shift_byte;
    cmd_next         = cmd;
    line_clk_next    = line_clk;
    line_dio_next    = line_dio;
    go_en            = 1'b0;
    go_ph            = PH_IDLE;
    done_w           = 1'b0;
    status_w         = 1'b0;
    data_bit         = 1'b0;
    dur              = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;

    unique case (cmd)
      sstw_pkg::KIND_DIGITS: more = (byte_index < 3'd4);
      sstw_pkg::KIND_ALLON:  more = (byte_index != 3'd0) && (byte_index < 3'd5);
      default:               more = 1'b0;
    endcase

    if (phase == PH_IDLE) begin
      if (start) begin
        cmd_next        = item.kind;
        byte_index_next = 3'd0;
        bit_index_next  = 3'd0;
        shift_byte_next = item.first_byte;
        go_en           = 1'b1;
        go_ph           = PH_START1;
      end
    end else if (delay_count != 16'd0) begin
      delay_count_next = delay_count - 16'd1;
    end else begin
      unique case (phase)
        PH_START1: begin
          go_en = 1'b1;
          go_ph = PH_START2;
        end
        PH_START2: begin
          bit_index_next = 3'd0;
          go_en          = 1'b1;
          go_ph          = PH_BIT_LOW;
        end
        PH_BIT_LOW: begin
          go_en = 1'b1;
          go_ph = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          go_en = 1'b1;
          if (bit_index == 3'd7) begin
            go_ph = PH_ACK1;
          end else begin
            bit_index_next = bit_index + 3'd1;
            go_ph          = PH_BIT_LOW;
          end
        end
        PH_ACK1: begin
          go_en = 1'b1;
          go_ph = PH_ACK2;
        end
        PH_ACK2: begin
          // bit index holds the missing-acknowledge flag until the slot ends
          bit_index_next = {2'b00, item.dio_in};
          go_en          = 1'b1;
          go_ph          = PH_ACK3;
        end
        PH_ACK3: begin
          if (bit_index != 3'd0) begin
            phase_next = PH_IDLE;
            done_w     = 1'b1;
            status_w   = 1'b1;
          end else if (more) begin
            byte_index_next = byte_index + 3'd1;
            shift_byte_next = (cmd == sstw_pkg::KIND_DIGITS) ? seg[byte_index[1:0]]
                                                             : sstw_pkg::ALL_SEG;
            bit_index_next  = 3'd0;
            go_en           = 1'b1;
            go_ph           = PH_BIT_LOW;
          end else begin
            go_en = 1'b1;
            go_ph = PH_STOP1;
          end
        end
        PH_STOP1: begin
          go_en = 1'b1;
          go_ph = PH_STOP2;
        end
        PH_STOP2: begin
          go_en = 1'b1;
          go_ph = PH_STOP3;
        end
        PH_STOP3: begin
          if (cmd == sstw_pkg::KIND_ALLON && byte_index == 3'd0) begin
            byte_index_next = 3'd1;
            shift_byte_next = sstw_pkg::ADDR_CMD;
            go_en           = 1'b1;
            go_ph           = PH_START1;
          end else begin
            phase_next = PH_IDLE;
            done_w     = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (go_en) begin
      phase_next       = go_ph;
      delay_count_next = (go_ph == PH_BIT_LOW) ? 16'd0 : dur - 16'd1;
      data_bit         = shift_byte_next[bit_index_next];
      unique case (go_ph)
        PH_START1:   begin line_clk_next = 1'b1; line_dio_next = 1'b1;     end
        PH_START2:   begin line_clk_next = 1'b1; line_dio_next = 1'b0;     end
        PH_BIT_LOW:  begin line_clk_next = 1'b0; line_dio_next = data_bit; end
        PH_BIT_HIGH: begin line_clk_next = 1'b1; line_dio_next = data_bit; end
        PH_ACK1:     begin line_clk_next = 1'b0; line_dio_next = 1'b1;     end
        PH_ACK2:     begin line_clk_next = 1'b1; line_dio_next = 1'b1;     end
        PH_ACK3:     begin line_clk_next = 1'b0; line_dio_next = 1'b1;     end
        PH_STOP1:    begin line_clk_next = 1'b0; line_dio_next = 1'b0;     end
        PH_STOP2:    begin line_clk_next = 1'b1; line_dio_next = 1'b0;     end
        PH_STOP3:    begin line_clk_next = 1'b1; line_dio_next = 1'b1;     end
        default:     begin line_clk_next = line_clk; line_dio_next = line_dio; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && start && item.kind == sstw_pkg::KIND_DIGITS) begin
      seg <= item.seg;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      clk_level <= line_clk_next;
      dio_level <= line_dio_next;
      busy_res  <= (phase_next != PH_IDLE);
      done_res  <= done_w;
      status    <= status_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= sstw_pkg::DELAY_RESET;
      phase       <= PH_IDLE;
      delay_count <= 16'd0;
      bit_index   <= 3'd0;
      byte_index  <= 3'd0;
      shift_byte  <= 8'd0;
      cmd         <= sstw_pkg::KIND_TICK;
      line_clk    <= 1'b1;
      line_dio    <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        delay_ticks <= cfg_data;
      end
      if (pop) begin
        phase       <= phase_next;
        delay_count <= delay_count_next;
        bit_index   <= bit_index_next;
        byte_index  <= byte_index_next;
        shift_byte  <= shift_byte_next;
        cmd         <= cmd_next;
        line_clk    <= line_clk_next;
        line_dio    <= line_dio_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idle_no_delay: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> delay_count == 16'd0)
    else $error("idle with delay pending");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done word still busy");

  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> done_res)
    else $error("status without done");

  a_abort_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !clk_level && dio_level)
    else $error("abort left wrong line levels");

endmodule
